// ===== src/bdq_pkg.sv =====
// bdq_pkg: request codes, status codes and fixed field widths of the bounded deque.
// Depends on nothing; imported by the deque core.
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int KIND_W   = 3;
   localparam int WORD_W   = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam kind_type KIND_PUSH_BACK  = 3'd0;
   localparam kind_type KIND_PUSH_FRONT = 3'd1;
   localparam kind_type KIND_POP_FRONT  = 3'd2;
   localparam kind_type KIND_POP_BACK   = 3'd3;
   localparam kind_type KIND_CONTAINS   = 3'd4;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   localparam count_type CAP_RESET = 5'd16;

endpackage

// ===== src/bdq_ram.sv =====
// bdq_ram: generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/bounded_deque_with_search_core.sv =====
// Bounded deque with search: push or pop at either end plus a contains query; uses bdq_pkg, bdq_ram.
// Path to the result beat: push, rejected request or unknown kind go through ST_RESP; pop goes
// through ST_READ then ST_RESP; a contains query walks the stored entries in ST_SCAN (one stored
// entry read per cycle, early stop on a match) before ST_RESP. One request is in flight at a time;
// the next is taken once the result sits in the output register.
// Synchronous active-high reset empties the deque, sets head to slot 0 and capacity to 16.
`timescale 1ns / 1ps

module bounded_deque_with_search_core
   import bdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   // configuration: capacity register
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [WORD_W-1:0]   req_value,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_popped,
   output logic                rsp_found,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Slot that lies off entries behind base, wrapped once around the ring.
   function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                                input logic [COUNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      cap_ff, cap_in;
   logic [ELEM_WIDTH-1:0]   word_ff, word_in;
   logic [COUNT_W-1:0]      scan_off_ff, scan_off_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic                    cmp_ff, cmp_in;
   logic [WORD_W-1:0]       res_popped_ff, res_popped_in;
   logic                    res_found_ff, res_found_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [COUNT_W-1:0]      res_count_ff, res_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]       rsp_popped_ff, rsp_popped_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [ELEM_WIDTH-1:0]   ram_rd_data;

   logic                    req_accept;
   logic [SUM_W-1:0]        eff_cap;
   logic                    is_full;
   logic                    is_empty;
   logic                    hit;

   bdq_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value[ELEM_WIDTH-1:0]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Capacity saturates at the built depth; a capacity of zero rejects every push.
   assign eff_cap  = (SUM_W'(cap_ff) > DEPTH_S) ? DEPTH_S : SUM_W'(cap_ff);
   assign is_full  = SUM_W'(count_ff) >= eff_cap;
   assign is_empty = (count_ff == '0);

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // A scan hit is judged on the word read out in the previous cycle.
   assign hit = cmp_ff && (ram_rd_data == word_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      word_in       = word_ff;
      scan_off_in   = scan_off_ff;
      ptr_in        = ptr_ff;
      cmp_in        = 1'b0;
      res_popped_in = res_popped_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_at(head_ff, count_ff);
      ram_rd_addr   = ptr_ff;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      // Drop the result beat once the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               word_in       = req_value[ELEM_WIDTH-1:0];
               res_popped_in = '0;
               res_found_in  = 1'b0;
               res_status_in = STATUS_DONE;
               res_count_in  = count_ff;
               state_in      = ST_RESP;
               unique case (req_kind)
                  KIND_PUSH_BACK: begin
                     if (is_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = slot_at(head_ff, count_ff);
                        count_in     = count_ff + 1'b1;
                        res_count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_PUSH_FRONT: begin
                     if (is_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        head_in      = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
                        count_in     = count_ff + 1'b1;
                        res_count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (is_empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        ram_rd_addr  = head_ff;
                        head_in      = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                        count_in     = count_ff - 1'b1;
                        res_count_in = count_ff - 1'b1;
                        state_in     = ST_READ;
                     end
                  end
                  KIND_POP_BACK: begin
                     if (is_empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        ram_rd_addr  = slot_at(head_ff, count_ff - 1'b1);
                        count_in     = count_ff - 1'b1;
                        res_count_in = count_ff - 1'b1;
                        state_in     = ST_READ;
                     end
                  end
                  KIND_CONTAINS: begin
                     // Start the walk at the front entry.
                     scan_off_in = '0;
                     ptr_in      = head_ff;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     // Unknown kind: report the current count and change nothing.
                  end
               endcase
            end
         end

         ST_READ: begin
            // Capture the popped word from the registered RAM read.
            res_popped_in = WORD_W'(ram_rd_data);
            state_in      = ST_RESP;
         end

         ST_SCAN: begin
            // One read issued per cycle, compared in the next cycle.
            if (hit) begin
               res_found_in = 1'b1;
               state_in     = ST_RESP;
            end else if (scan_off_ff >= count_ff && !cmp_ff) begin
               state_in = ST_RESP;
            end else if (scan_off_ff < count_ff) begin
               ram_rd_addr = ptr_ff;
               ptr_in      = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
               scan_off_in = scan_off_ff + 1'b1;
               cmp_in      = 1'b1;
            end
         end

         ST_RESP: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = res_popped_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         cmp_ff       <= cmp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff       <= word_in;
      scan_off_ff   <= scan_off_in;
      ptr_ff        <= ptr_in;
      res_popped_ff <= res_popped_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_popped = rsp_popped_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for bounded_deque_with_search_core: push, pop and search requests with a
// built-in predictor, random idling on both channels and capacity changes between phases.
// Depends on bdq_pkg and the deque core with its RAM.
`timescale 1ns / 1ps

module testbench
   import bdq_pkg::*;
();

   localparam int DEPTH       = 16;
   localparam int SETTLE      = 24;    // settling wait after the last result; covers the longest search
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the pressure phase
   localparam int QUIET_LIMIT = 3000;  // cycles with no beat on either channel

   // one expected result beat
   typedef struct packed {
      logic [WORD_W-1:0] popped;
      logic              found;
      status_type        status;
      count_type         count;
   } deque_rsp_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   count_type         csr_wr_data = '0;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   kind_type          req_kind    = KIND_PUSH_BACK;
   logic [WORD_W-1:0] req_value   = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   logic [WORD_W-1:0] rsp_popped;
   logic              rsp_found;
   status_type        rsp_status;
   count_type         rsp_count;

   // shadow of the deque: stored words, front slot, fill level, capacity register
   logic [WORD_W-1:0] store_model [DEPTH];
   int                head_model = 0;
   int                fill_model = 0;
   int                cap_model  = CAP_RESET;

   deque_rsp_type     expected_rsp [$];
   int                mismatches   = 0;
   int                idle_pct     = 0;   // chance the sender skips a cycle
   int                stall_pct    = 0;   // chance the receiver stalls a cycle
   logic              hold_active  = 1'b0;
   event              hold_go;
   int                quiet_cycles = 0;

   bounded_deque_with_search_core #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (WORD_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_popped  (rsp_popped),
      .rsp_found   (rsp_found),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Compute the result of one accepted request and advance the shadow state.
   // Full and empty rejections leave the state untouched; unknown kinds only report the count.
   function automatic deque_rsp_type predict_deque(kind_type kind, logic [WORD_W-1:0] word);
      deque_rsp_type r;
      int            room;
      int            i;
      r = '0;
      // capacity above the built depth saturates at the depth
      room = (cap_model > DEPTH) ? DEPTH : cap_model;
      case (kind)
         KIND_PUSH_BACK: begin
            if (fill_model >= room) begin
               r.status = STATUS_FULL;
            end else begin
               store_model[(head_model + fill_model) % DEPTH] = word;
               fill_model++;
            end
         end
         KIND_PUSH_FRONT: begin
            if (fill_model >= room) begin
               r.status = STATUS_FULL;
            end else begin
               head_model = (head_model + DEPTH - 1) % DEPTH;
               store_model[head_model] = word;
               fill_model++;
            end
         end
         KIND_POP_FRONT: begin
            if (fill_model == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.popped   = store_model[head_model];
               head_model = (head_model + 1) % DEPTH;
               fill_model--;
            end
         end
         KIND_POP_BACK: begin
            if (fill_model == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.popped = store_model[(head_model + fill_model - 1) % DEPTH];
               fill_model--;
            end
         end
         KIND_CONTAINS: begin
            // scan only the live entries, front to back
            for (i = 0; i < fill_model; i++) begin
               if (!r.found && store_model[(head_model + i) % DEPTH] == word)
                  r.found = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.count = count_type'(fill_model);
      return r;
   endfunction

   // Offer one request beat, idling first at random; predict it at the edge that takes it.
   task automatic send_request(kind_type kind, logic [WORD_W-1:0] word);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_rsp.push_back(predict_deque(kind, word));
   endtask

   // Drop valid and wait until every expected beat has arrived and the core has gone quiet.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write the capacity register while the core is idle.
   task automatic write_capacity(count_type cap);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_model = cap;
   endtask

   task automatic set_idling(int tx_pct, int rx_pct);
      idle_pct  = tx_pct;
      stall_pct = rx_pct;
   endtask

   // Mostly full-width random words, some tiny ones so that searches collide.
   function automatic logic [WORD_W-1:0] rand_word;
      if ($urandom_range(3) == 0)
         return WORD_W'($urandom_range(15));
      return {$urandom, $urandom};
   endfunction

   // Random requests in windows that alternate between filling and draining the deque.
   task automatic run_random(int n);
      int                push_pct;
      int                r;
      kind_type          kind;
      logic [WORD_W-1:0] word;
      for (int i = 0; i < n; i++) begin
         push_pct = ((i / 24) % 2 == 0) ? 90 : 15;
         r        = $urandom_range(99);
         word     = rand_word();
         if (r < 4) begin
            // noise: unknown kinds
            kind = kind_type'($urandom_range(7, 5));
         end else if (r < 22) begin
            kind = KIND_CONTAINS;
            // search for a live entry about half the time
            if (fill_model > 0 && $urandom_range(1) == 1)
               word = store_model[(head_model + $urandom_range(fill_model - 1)) % DEPTH];
         end else if (r < 22 + (push_pct * 78) / 100) begin
            kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
         end else begin
            kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
         end
         send_request(kind, word);
      end
   endtask

   // Empty-list rejections, both ends, extreme words, searches and unknown kinds.
   task automatic test_basic_ops;
      set_idling(0, 0);
      send_request(KIND_POP_FRONT, '0);
      send_request(KIND_POP_BACK, '1);
      send_request(KIND_CONTAINS, '0);
      send_request(KIND_PUSH_BACK, '0);
      send_request(KIND_PUSH_BACK, '1);
      send_request(KIND_PUSH_FRONT, 64'h8000_0000_0000_0001);
      send_request(KIND_CONTAINS, '1);
      send_request(KIND_CONTAINS, 64'd5);
      send_request(kind_type'(5), 64'h0123_4567_89ab_cdef);
      send_request(kind_type'(6), '0);
      send_request(kind_type'(7), '1);
      send_request(KIND_POP_BACK, '0);
      send_request(KIND_POP_FRONT, '0);
      send_request(KIND_POP_FRONT, '1);
      send_request(KIND_POP_BACK, '0);
   endtask

   // Capacity of one and of zero: pushes past the limit come back full.
   task automatic test_capacity_edges;
      write_capacity(count_type'(1));
      send_request(KIND_PUSH_BACK, 64'hdead_beef_0000_0001);
      send_request(KIND_PUSH_FRONT, 64'h5555_aaaa_5555_aaaa);
      send_request(KIND_CONTAINS, 64'hdead_beef_0000_0001);
      send_request(KIND_POP_BACK, '0);
      write_capacity(count_type'(0));
      send_request(KIND_PUSH_BACK, 64'h1);
      send_request(KIND_PUSH_FRONT, 64'h2);
   endtask

   // Random phases across capacities and idling patterns.
   task automatic test_random_phases;
      write_capacity(CAP_RESET);
      set_idling(0, 0);
      run_random(100);
      // above the built depth: saturates at 16
      write_capacity(count_type'(31));
      set_idling(77, 0);
      run_random(100);
      write_capacity(count_type'(5));
      set_idling(0, 77);
      run_random(90);
      write_capacity(count_type'(1));
      set_idling(37, 37);
      run_random(70);
      write_capacity(count_type'(0));
      run_random(20);
      write_capacity(CAP_RESET);
      run_random(100);
   endtask

   // Lower the capacity below the fill level: entries stay, pushes bounce until pops catch up.
   task automatic test_capacity_shrink;
      write_capacity(CAP_RESET);
      set_idling(37, 37);
      while (fill_model < 12)
         send_request($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, rand_word());
      write_capacity(count_type'(3));
      repeat (4) send_request(KIND_PUSH_BACK, rand_word());
      run_random(40);
   endtask

   // Hold the receiver off for a long stretch while requests keep coming.
   task automatic test_backpressure;
      write_capacity(CAP_RESET);
      set_idling(0, 0);
      -> hold_go;
      run_random(15);
      set_idling(0, 37);
   endtask

   // Count the hold-off in its own process.
   initial begin
      forever begin
         @(hold_go);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // Receiver: stall at random, or solidly during a hold-off.
   always @(posedge clock) begin
      if (hold_active)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Check each result beat against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      deque_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing expected, expected none, actual %0h/%0b/%0d/%0d",
                     $time, rsp_popped, rsp_found, rsp_status, rsp_count);
         end else begin
            want = expected_rsp.pop_front();
            report_field("popped", want.popped, rsp_popped);
            report_field("found", WORD_W'(want.found), WORD_W'(rsp_found));
            report_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
            report_field("count", WORD_W'(want.count), WORD_W'(rsp_count));
         end
      end
   end

   // Watchdog: end the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, expected_rsp.size());
         $display("bounded_deque_with_search_core test failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++)
         store_model[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_capacity_edges();
      test_random_phases();
      test_capacity_shrink();
      test_backpressure();
      drain();

      if (expected_rsp.size() != 0 || mismatches != 0)
         $display("bounded_deque_with_search_core test failed");
      else
         $display("bounded_deque_with_search_core test passed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bdq_pkg.sv
src/bdq_ram.sv
src/bounded_deque_with_search_core.sv
bench/testbench.sv
